/* src/kpc_pkg.sv */
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, codes and helpers for the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int unsigned TIMER_W = 16;
	localparam int unsigned LIMIT_W = 14;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;

	// Event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} ev_t;

	// Request kinds
	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_READ = 1'b1
	} req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 3'd5;

	typedef struct packed {
		logic               long_enable;
		logic               double_enable;
		logic [STEP_W-1:0]  tick_step_ms;
		logic [LIMIT_W-1:0] long_limit_ms;
		logic [LIMIT_W-1:0] short_limit_ms;
		logic [LIMIT_W-1:0] double_window_ms;
	} cfg_t;

	typedef struct packed {
		logic                level_now;
		logic                level_before;
		logic [TIMER_W-1:0]  hold_timer;
		logic [TIMER_W-1:0]  window_timer;
		logic                first_click_seen;
		ev_t                 latched_event;
	} state_t;

	// Saturating timer advance
	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
			input logic [STEP_W-1:0] b);
		logic [TIMER_W:0] sum;
		sum = {1'b0, a} + {{(TIMER_W + 1 - STEP_W){1'b0}}, b};
		sat_add = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
	endfunction

endpackage

/* src/kpc_update.sv */
// ----------------------------------------------------------------------------
// kpc_update
// Next-state logic for one request: tick with key sample, or read and clear.
// ----------------------------------------------------------------------------
module kpc_update (
	input  kpc_pkg::cfg_t   cfg,
	input  kpc_pkg::state_t cur,
	input  kpc_pkg::req_t   req_type,
	input  logic            key_pressed,
	output kpc_pkg::state_t nxt,
	output kpc_pkg::ev_t    read_event
);

	always_comb begin
		kpc_pkg::state_t        s;
		logic [kpc_pkg::TIMER_W-1:0] long_lim;
		logic [kpc_pkg::TIMER_W-1:0] short_lim;
		logic [kpc_pkg::TIMER_W-1:0] window_lim;
		s          = cur;
		read_event = kpc_pkg::EV_NONE;
		long_lim   = {2'b00, cfg.long_limit_ms};
		short_lim  = {2'b00, cfg.short_limit_ms};
		window_lim = {2'b00, cfg.double_window_ms};

		if (req_type == kpc_pkg::REQ_READ) begin
			// hand out the latched event and clear it
			read_event      = cur.latched_event;
			s.latched_event = kpc_pkg::EV_NONE;
		end else begin
			// shift in the new level
			s.level_before = cur.level_now;
			s.level_now    = key_pressed;

			// restart hold timing on a press edge
			if (!s.level_before && s.level_now && cfg.long_enable) begin
				s.hold_timer = '0;
			end

			// advance hold timer while held
			if (s.level_before && s.level_now && (s.hold_timer <= long_lim) &&
					cfg.long_enable) begin
				s.hold_timer = kpc_pkg::sat_add(s.hold_timer, cfg.tick_step_ms);
			end

			// long press: latch and park the timer above the short limit
			if (s.level_before && (s.hold_timer > long_lim) && cfg.long_enable) begin
				s.latched_event = kpc_pkg::EV_LONG;
				s.hold_timer    = short_lim + 16'd1;
			end

			// short release: report, open a window, or close it as double
			if (s.level_before && !s.level_now && (s.hold_timer <= short_lim)) begin
				if (!cfg.double_enable) begin
					s.latched_event = kpc_pkg::EV_SHORT;
				end else if (!s.first_click_seen) begin
					s.first_click_seen = 1'b1;
					s.window_timer     = '0;
				end else if (s.window_timer <= window_lim) begin
					s.latched_event    = kpc_pkg::EV_DOUBLE;
					s.first_click_seen = 1'b0;
				end
			end

			// run the click window; expiry counts as a single short press
			if (s.first_click_seen) begin
				s.window_timer = kpc_pkg::sat_add(s.window_timer, cfg.tick_step_ms);
				if (s.window_timer > window_lim) begin
					s.latched_event    = kpc_pkg::EV_SHORT;
					s.first_click_seen = 1'b0;
				end
			end
		end
		nxt = s;
	end

endmodule

/* src/key_press_classifier.sv */
// ----------------------------------------------------------------------------
// key_press_classifier
// Short / long / double press classifier for one button, driven by ticks.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_*      | in        | s_tvalid / s_tready | tdata: key_pressed; tuser: req_type
//  m_*      | out       | m_tvalid / m_tready | tdata: read_event, pending_event
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled. An accepted request
// is registered in the input register, then the result register is loaded
// from the update logic.
// arst_n clears config to its defaults, all timers, levels and the latched event.
// A stalled result holds both stages; the input side keeps taking requests
// while the input register is empty or the result moves on.
// cfg_ready is always high; writes take effect at the next edge.
// ----------------------------------------------------------------------------
module key_press_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] key_pressed, [7:1] zero
	input  logic [0:0] s_tuser,   // [0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [1:0] read_event, [3:2] pending_event, [7:4] zero
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data
);

	kpc_pkg::cfg_t   cfg_q;
	kpc_pkg::state_t state_q;
	kpc_pkg::state_t state_nxt;
	kpc_pkg::ev_t    read_ev;
	kpc_pkg::req_t   req_s1;
	logic            key_s1;
	logic            valid_s1;
	logic            advance;
	logic [3:0]      result_s2;
	logic            valid_s2;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_enable      <= 1'b1;
			cfg_q.double_enable    <= 1'b0;
			cfg_q.tick_step_ms     <= 8'd20;
			cfg_q.long_limit_ms    <= 14'd800;
			cfg_q.short_limit_ms   <= 14'd200;
			cfg_q.double_window_ms <= 14'd200;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kpc_pkg::CFG_LONG_ENABLE:   cfg_q.long_enable      <= cfg_data[0];
				kpc_pkg::CFG_DOUBLE_ENABLE: cfg_q.double_enable    <= cfg_data[0];
				kpc_pkg::CFG_TICK_STEP:     cfg_q.tick_step_ms     <= cfg_data[7:0];
				kpc_pkg::CFG_LONG_LIMIT:    cfg_q.long_limit_ms    <= cfg_data;
				kpc_pkg::CFG_SHORT_LIMIT:   cfg_q.short_limit_ms   <= cfg_data;
				kpc_pkg::CFG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= kpc_pkg::req_t'(s_tuser[0]);
			key_s1 <= s_tdata[0];
		end
	end

	kpc_update u_update (
		.cfg         (cfg_q),
		.cur         (state_q),
		.req_type    (req_s1),
		.key_pressed (key_s1),
		.nxt         (state_nxt),
		.read_event  (read_ev)
	);

	// commit state and result together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= {state_nxt.latched_event, read_ev};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, result_s2};

`ifndef SYNTHESIS
	// a read leaves nothing pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && req_s1 == kpc_pkg::REQ_READ)
		|=> (m_tdata[3:2] == kpc_pkg::EV_NONE))
		else $error("pending event not cleared by read");

	// a tick returns no read event
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && req_s1 == kpc_pkg::REQ_TICK)
		|=> (m_tdata[1:0] == kpc_pkg::EV_NONE))
		else $error("tick returned a read event");

	// a stalled result freezes the classifier state
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(state_q))
		else $error("state changed while result stalled");
`endif

endmodule
